### rtl/assert_macros.svh
// Assertion helpers shared by the list modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define COL_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
		else $error("list assertion failed");

// The antecedent at one edge implies the consequent at the next edge.
`define COL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("list assertion failed");

`endif

### rtl/col_pkg.sv
`default_nettype none

package col_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int OP_W     = 4;
	localparam int ST_W     = 2;
	localparam int POS_W    = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 4'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 4'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 4'd2;
	localparam logic [OP_W-1:0] OP_START  = 4'd3;
	localparam logic [OP_W-1:0] OP_END    = 4'd4;
	localparam logic [OP_W-1:0] OP_PREV   = 4'd5;
	localparam logic [OP_W-1:0] OP_NEXT   = 4'd6;
	localparam logic [OP_W-1:0] OP_GET    = 4'd7;
	localparam logic [OP_W-1:0] OP_CLEAR  = 4'd8;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_NONE = 2'd2;

	typedef struct packed {
		logic            load;
		logic            ins;
		logic            app;
		logic            rem;
		logic            rd;
		logic            clr;
		logic            cur_zero;
		logic            cur_end;
		logic            cur_dec;
		logic            cur_inc;
		logic [ST_W-1:0] status;
	} col_cmd_t;

	typedef struct packed {
		logic full;
		logic at_end;
		logic at_start;
	} col_stat_t;

	typedef struct packed {
		logic [VAL_W-1:0] hi;
		logic [VAL_W-1:0] lo;
	} col_pair_t;

endpackage

`default_nettype wire

### rtl/col_ctrl.sv
`default_nettype none

module col_ctrl
	import col_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire logic [OP_W-1:0] operation,
	output logic                 res_valid,
	input  wire logic            res_ready,
	input  wire col_stat_t       stat,
	output col_cmd_t             cmd
);

	localparam logic [0:0] S_EMPTY = 1'b0;
	localparam logic [0:0] S_HELD  = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       acc;

	assign res_valid = (state_q == S_HELD);
	assign req_ready = (state_q == S_EMPTY) || res_ready;
	assign acc       = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_EMPTY: begin
				if (acc) state_d = S_HELD;
			end
			S_HELD: begin
				if (res_ready && !acc) state_d = S_EMPTY;
			end
			default: state_d = S_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		col_cmd_t c;
		c        = '0;
		c.status = ST_OK;
		unique case (operation)
			OP_INSERT: begin
				if (stat.full) c.status = ST_FULL;
				else c.ins = 1'b1;
			end
			OP_APPEND: begin
				if (stat.full) c.status = ST_FULL;
				else c.app = 1'b1;
			end
			OP_REMOVE: begin
				if (stat.at_end) c.status = ST_NONE;
				else begin
					c.rem = 1'b1;
					c.rd  = 1'b1;
				end
			end
			OP_START: c.cur_zero = 1'b1;
			OP_END:   c.cur_end = 1'b1;
			OP_PREV: begin
				if (stat.at_start) c.status = ST_NONE;
				else c.cur_dec = 1'b1;
			end
			OP_NEXT: begin
				if (stat.at_end) c.status = ST_NONE;
				else c.cur_inc = 1'b1;
			end
			OP_GET: begin
				if (stat.at_end) c.status = ST_NONE;
				else c.rd = 1'b1;
			end
			OP_CLEAR: c.clr = 1'b1;
			default:  c.status = ST_NONE;
		endcase
		if (!acc) c = '0;
		c.load = acc;
		cmd    = c;
	end

	`include "assert_macros.svh"

	`COL_ASSERT_NEXT(a_acc_gives_result, clk, arst_n, acc, res_valid)
	`COL_ASSERT_ALWAYS(a_one_update, clk, arst_n,
		$countones({cmd.ins, cmd.app, cmd.rem, cmd.clr}) <= 1)

endmodule

`default_nettype wire

### rtl/col_dpath.sv
`default_nettype none

module col_dpath
	import col_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire col_cmd_t         cmd,
	input  wire logic [VAL_W-1:0] item_start,
	input  wire logic [VAL_W-1:0] item_end,
	output col_stat_t             stat,
	output logic      [VAL_W-1:0] out_start,
	output logic      [VAL_W-1:0] out_end,
	output logic      [ST_W-1:0]  status,
	output logic      [POS_W-1:0] list_length,
	output logic      [POS_W-1:0] cursor_position
);

	col_pair_t        cells_q [CAPACITY];
	col_pair_t        cells_d [CAPACITY];
	col_pair_t        item;
	col_pair_t        got;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] cursor_q;
	logic [CNT_W-1:0] cursor_d;

	assign item.lo = item_start;
	assign item.hi = item_end;

	assign stat.full     = (count_q == CNT_W'(CAPACITY));
	assign stat.at_end   = (cursor_q >= count_q);
	assign stat.at_start = (cursor_q == '0);

	// Every cell decides from its own index whether it takes the new pair,
	// its lower neighbor (insert) or its upper neighbor (remove).
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		always_comb begin
			cells_d[g] = cells_q[g];
			if (cmd.ins) begin
				if (CNT_W'(g) == cursor_q) cells_d[g] = item;
				else if (CNT_W'(g) > cursor_q) begin
					if (g > 0) cells_d[g] = cells_q[(g > 0) ? g - 1 : 0];
				end
			end else if (cmd.app) begin
				if (CNT_W'(g) == count_q) cells_d[g] = item;
			end else if (cmd.rem) begin
				if (CNT_W'(g) >= cursor_q && g < CAPACITY - 1) begin
					cells_d[g] = cells_q[(g < CAPACITY - 1) ? g + 1 : g];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			cells_q[i] <= cells_d[i];
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.clr) count_d = '0;
		else if (cmd.ins || cmd.app) count_d = count_q + 1'b1;
		else if (cmd.rem) count_d = count_q - 1'b1;
	end

	always_comb begin
		cursor_d = cursor_q;
		if (cmd.clr || cmd.cur_zero) cursor_d = '0;
		else if (cmd.cur_end) cursor_d = count_q;
		else if (cmd.cur_dec) cursor_d = cursor_q - 1'b1;
		else if (cmd.cur_inc) cursor_d = cursor_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
		end
	end

	always_comb begin
		got = '0;
		if (cmd.rd) got = cells_q[cursor_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_start       <= got.lo;
			out_end         <= got.hi;
			status          <= cmd.status;
			list_length     <= POS_W'(count_d);
			cursor_position <= POS_W'(cursor_d);
		end
	end

	`include "assert_macros.svh"

	`COL_ASSERT_ALWAYS(a_cursor_in_range, clk, arst_n, cursor_q <= count_q)
	`COL_ASSERT_ALWAYS(a_count_in_range, clk, arst_n, count_q <= CNT_W'(CAPACITY))

endmodule

`default_nettype wire

### rtl/cursor_ordered_list.sv
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while m_tready keeps taking results; no operation
// takes extra states, since all cells compare their index with the cursor and shift at once.
// The result register frees when taken, so a new request enters in the same cycle.
// Reset clears the entry count, the cursor and the result valid; entries are not cleared.
`default_nettype none

module cursor_ordered_list
	import col_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // item_start [31:0], item_end [63:32]
	input  wire logic [3:0]  s_tuser,  // operation [3:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [79:0] m_tdata   // out_start [31:0], out_end [63:32],
	                                   // status [65:64], list_length [70:66],
	                                   // cursor_position [75:71], zero [79:76]
);

	col_cmd_t         cmd;
	col_stat_t        stat;
	logic [VAL_W-1:0] out_start;
	logic [VAL_W-1:0] out_end;
	logic [ST_W-1:0]  status;
	logic [POS_W-1:0] list_length;
	logic [POS_W-1:0] cursor_position;

	col_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.operation (s_tuser),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	col_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.item_start      (s_tdata[31:0]),
		.item_end        (s_tdata[63:32]),
		.stat            (stat),
		.out_start       (out_start),
		.out_end         (out_end),
		.status          (status),
		.list_length     (list_length),
		.cursor_position (cursor_position)
	);

	assign m_tdata = {4'b0000, cursor_position, list_length, status, out_end, out_start};

endmodule

`default_nettype wire
